>>> src/pcrr_pkg.sv
// Shared types and constants of the per-CPU round robin scheduler.
package pcrr_pkg;

	localparam int THREADS = 64;
	localparam int TW      = 6;
	localparam int CPUS    = 4;
	localparam int CW      = 2;
	localparam int QW      = 7;

	localparam logic [1:0] KIND_ENQ   = 2'd0;
	localparam logic [1:0] KIND_DEQ   = 2'd1;
	localparam logic [1:0] KIND_SCHED = 2'd2;

	localparam logic [1:0] ST_NOT_READY = 2'd0;
	localparam logic [1:0] ST_READY     = 2'd1;
	localparam logic [1:0] ST_TAKEN     = 2'd2;
	localparam logic [1:0] ST_EXITED    = 2'd3;

	localparam logic [7:0] BUDGET_RESET = 8'd2;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_EXA  = 6'b000100,
		S_RDB  = 6'b001000,
		S_EXB  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic latch;
		logic rd_a;
		logic ex_a;
		logic rd_b;
		logic ex_b;
	} cmd_t;

	typedef struct packed {
		logic choose;
	} sts_t;

endpackage

>>> src/pcrr_ctrl.sv
// Sequencer of the scheduler: steps each item through read and update phases.
module pcrr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  pcrr_pkg::sts_t sts,
	output pcrr_pkg::cmd_t cmd
);

	pcrr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcrr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcrr_pkg::S_IDLE: if (s_tvalid) state_d = pcrr_pkg::S_RDA;
			pcrr_pkg::S_RDA:  state_d = pcrr_pkg::S_EXA;
			pcrr_pkg::S_EXA:  state_d = sts.choose ? pcrr_pkg::S_RDB : pcrr_pkg::S_OUT;
			pcrr_pkg::S_RDB:  state_d = pcrr_pkg::S_EXB;
			pcrr_pkg::S_EXB:  state_d = pcrr_pkg::S_OUT;
			pcrr_pkg::S_OUT:  if (m_tready) state_d = pcrr_pkg::S_IDLE;
			default:          state_d = pcrr_pkg::S_IDLE;
		endcase
	end

	assign s_tready  = (state_q == pcrr_pkg::S_IDLE);
	assign m_tvalid  = (state_q == pcrr_pkg::S_OUT);
	assign cmd.latch = s_tready && s_tvalid;
	assign cmd.rd_a  = (state_q == pcrr_pkg::S_RDA);
	assign cmd.ex_a  = (state_q == pcrr_pkg::S_EXA);
	assign cmd.rd_b  = (state_q == pcrr_pkg::S_RDB);
	assign cmd.ex_b  = (state_q == pcrr_pkg::S_EXB);

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == pcrr_pkg::S_RDA)
		else $error("accepted item did not start a read");
	a_no_choose_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcrr_pkg::S_EXA && !sts.choose |=> m_tvalid)
		else $error("finished item not presented");
	a_head_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcrr_pkg::S_RDB |=> state_q == pcrr_pkg::S_EXB)
		else $error("head read not followed by update");
`endif

endmodule

>>> src/pcrr_dp.sv
// Datapath of the scheduler: thread tables, queue registers and result register.
module pcrr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  pcrr_pkg::cmd_t cmd,
	output pcrr_pkg::sts_t sts,
	input  logic           budget_we,
	input  logic [7:0]     budget_wdata,
	input  logic [1:0]     in_kind,
	input  logic [5:0]     in_thread,
	input  logic           in_idle,
	input  logic           in_noaff,
	input  logic [7:0]     in_aff,
	input  logic [1:0]     in_cpu,
	input  logic           in_exit,
	input  logic           in_wait,
	input  logic [7:0]     in_budget,
	output logic           status,
	output logic           switched,
	output logic [5:0]     pick_thread,
	output logic           chosen_is_idle,
	output logic [7:0]     granted_budget,
	output logic           retired_current,
	output logic [6:0]     queue_length
);

	localparam int TW = pcrr_pkg::TW;
	localparam int CW = pcrr_pkg::CW;
	localparam int QW = pcrr_pkg::QW;

	logic [1:0]    kind_q;
	logic [TW-1:0] t_q;
	logic          idle_q, noaff_q, exit_q, wait_q, ret_q;
	logic [7:0]    aff_q, bud_q, dflt_q;
	logic [CW-1:0] cpu_q;

	logic [1:0]    stat_mem [pcrr_pkg::THREADS];
	logic [8:0]    aff_mem  [pcrr_pkg::THREADS];
	logic [TW-1:0] nxt_mem  [pcrr_pkg::THREADS];
	logic [TW-1:0] prv_mem  [pcrr_pkg::THREADS];
	logic [CW-1:0] qcpu_mem [pcrr_pkg::THREADS];
	logic [pcrr_pkg::THREADS-1:0] vld_q;

	logic [1:0]    stat_rd_q;
	logic          vld_rd_q;
	logic [8:0]    aff_rd_q;
	logic [TW-1:0] nxt_rd_q, prv_rd_q, addr_q, rd_addr;
	logic [CW-1:0] qcpu_rd_q;

	logic [TW-1:0] first_q [pcrr_pkg::CPUS];
	logic [TW-1:0] last_q  [pcrr_pkg::CPUS];
	logic [QW-1:0] cnt_q   [pcrr_pkg::CPUS];
	logic [TW-1:0] run_thr_q [pcrr_pkg::CPUS];
	logic [pcrr_pkg::CPUS-1:0] run_vld_q, run_idle_q;

	logic [1:0]    stat_eff;
	logic          push_en, unl_en, ex_en, aff_we, run_we, run_idle_d, res_we;
	logic [TW-1:0] push_t, run_thr_d;
	logic [CW-1:0] push_c;
	logic [7:0]    enq_c, rq_c;
	logic [QW-1:0] cnt_cpu, cnt_uc;

	logic          r_status, r_sw, r_cidle, r_ret;
	logic [TW-1:0] r_chosen;
	logic [7:0]    r_grant;
	logic [QW-1:0] r_qlen;

	logic          stat_we, nxt_we, prv_we, qcpu_we, first_we, last_we, cnt_we;
	logic [TW-1:0] stat_wa, nxt_wa, nxt_wd, prv_wa, prv_wd, qcpu_wa, first_d, last_d;
	logic [1:0]    stat_wd;
	logic [CW-1:0] qcpu_wd, first_c, last_c, cnt_c;
	logic [QW-1:0] cnt_d;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= in_kind;
			t_q     <= in_thread;
			idle_q  <= in_idle;
			noaff_q <= in_noaff;
			aff_q   <= in_aff;
			cpu_q   <= in_cpu;
			exit_q  <= in_exit;
			wait_q  <= in_wait;
			bud_q   <= in_budget;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= pcrr_pkg::BUDGET_RESET;
		end else if (budget_we) begin
			dflt_q <= budget_wdata;
		end
	end

	always_comb begin
		if (cmd.rd_b) begin
			rd_addr = first_q[cpu_q];
		end else if (kind_q == pcrr_pkg::KIND_SCHED) begin
			rd_addr = run_thr_q[cpu_q];
		end else begin
			rd_addr = t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stat_we) stat_mem[stat_wa] <= stat_wd;
		if (aff_we) aff_mem[t_q] <= {noaff_q, aff_q};
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (qcpu_we) qcpu_mem[qcpu_wa] <= qcpu_wd;
		if (cmd.rd_a || cmd.rd_b) begin
			stat_rd_q <= stat_mem[rd_addr];
			vld_rd_q  <= vld_q[rd_addr];
			aff_rd_q  <= aff_mem[rd_addr];
			nxt_rd_q  <= nxt_mem[rd_addr];
			prv_rd_q  <= prv_mem[rd_addr];
			qcpu_rd_q <= qcpu_mem[rd_addr];
			addr_q    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (stat_we) begin
			vld_q[stat_wa] <= 1'b1;
		end
	end

	assign stat_eff = vld_rd_q ? stat_rd_q : pcrr_pkg::ST_NOT_READY;
	assign enq_c    = noaff_q ? {{(8-CW){1'b0}}, cpu_q} : aff_q;
	assign rq_c     = aff_rd_q[8] ? {{(8-CW){1'b0}}, cpu_q} : aff_rd_q[7:0];
	assign cnt_cpu  = cnt_q[cpu_q];
	assign cnt_uc   = cnt_q[qcpu_rd_q];

	always_comb begin
		push_en    = 1'b0;
		push_t     = addr_q;
		push_c     = cpu_q;
		unl_en     = 1'b0;
		ex_en      = 1'b0;
		aff_we     = 1'b0;
		run_we     = 1'b0;
		run_thr_d  = '0;
		run_idle_d = 1'b0;
		res_we     = 1'b0;
		sts.choose = 1'b0;
		r_status   = 1'b0;
		r_sw       = 1'b0;
		r_chosen   = '0;
		r_cidle    = 1'b0;
		r_grant    = '0;
		r_ret      = 1'b0;
		r_qlen     = '0;
		if (cmd.ex_a) begin
			case (kind_q)
				pcrr_pkg::KIND_ENQ: begin
					res_we = 1'b1;
					if (stat_eff == pcrr_pkg::ST_READY) begin
						r_status = 1'b1;
					end else if (idle_q) begin
						r_qlen = cnt_cpu;
					end else if (enq_c >= 8'(pcrr_pkg::CPUS)) begin
						r_status = 1'b1;
					end else begin
						aff_we  = 1'b1;
						push_en = 1'b1;
						push_t  = t_q;
						push_c  = enq_c[CW-1:0];
						r_qlen  = cnt_q[enq_c[CW-1:0]] + QW'(1);
					end
				end
				pcrr_pkg::KIND_DEQ: begin
					res_we = 1'b1;
					if (stat_eff != pcrr_pkg::ST_READY) begin
						r_status = 1'b1;
					end else if (!idle_q) begin
						unl_en = 1'b1;
						r_qlen = (cnt_uc != '0) ? cnt_uc - QW'(1) : cnt_uc;
					end else begin
						r_qlen = cnt_uc;
					end
				end
				pcrr_pkg::KIND_SCHED: begin
					sts.choose = 1'b1;
					if (run_vld_q[cpu_q]) begin
						if (exit_q) begin
							ex_en = !run_idle_q[cpu_q];
						end else if (wait_q) begin
							sts.choose = 1'b1;
						end else if (bud_q != '0) begin
							sts.choose = 1'b0;
							res_we     = 1'b1;
							r_qlen     = cnt_cpu;
						end else if (!run_idle_q[cpu_q] && stat_eff != pcrr_pkg::ST_READY
							&& rq_c < 8'(pcrr_pkg::CPUS)) begin
							push_en = 1'b1;
							push_c  = rq_c[CW-1:0];
						end
					end
				end
				default: begin
					res_we   = 1'b1;
					r_status = 1'b1;
				end
			endcase
		end else if (cmd.ex_b) begin
			res_we = 1'b1;
			if (cnt_cpu == '0) begin
				run_we     = 1'b1;
				run_idle_d = 1'b1;
				r_sw       = 1'b1;
				r_cidle    = 1'b1;
				r_ret      = ret_q;
			end else if (stat_eff != pcrr_pkg::ST_READY) begin
				r_status = 1'b1;
			end else begin
				unl_en    = 1'b1;
				run_we    = 1'b1;
				run_thr_d = addr_q;
				r_sw      = 1'b1;
				r_chosen  = addr_q;
				r_grant   = dflt_q;
				r_ret     = ret_q;
				r_qlen    = (qcpu_rd_q == cpu_q) ? cnt_cpu - QW'(1) : cnt_cpu;
			end
		end
	end

	always_comb begin
		stat_we  = 1'b0;
		stat_wa  = addr_q;
		stat_wd  = pcrr_pkg::ST_READY;
		nxt_we   = 1'b0;
		nxt_wa   = '0;
		nxt_wd   = '0;
		prv_we   = 1'b0;
		prv_wa   = '0;
		prv_wd   = '0;
		qcpu_we  = 1'b0;
		qcpu_wa  = push_t;
		qcpu_wd  = push_c;
		first_we = 1'b0;
		first_c  = push_c;
		first_d  = push_t;
		last_we  = 1'b0;
		last_c   = push_c;
		last_d   = push_t;
		cnt_we   = 1'b0;
		cnt_c    = push_c;
		cnt_d    = '0;
		if (push_en) begin
			if (cnt_q[push_c] == '0) begin
				first_we = 1'b1;
			end else begin
				nxt_we = 1'b1;
				nxt_wa = last_q[push_c];
				nxt_wd = push_t;
				prv_we = 1'b1;
				prv_wa = push_t;
				prv_wd = last_q[push_c];
			end
			last_we = 1'b1;
			cnt_we  = 1'b1;
			cnt_d   = cnt_q[push_c] + QW'(1);
			qcpu_we = 1'b1;
			stat_we = 1'b1;
			stat_wa = push_t;
		end else if (unl_en) begin
			first_c = qcpu_rd_q;
			first_d = nxt_rd_q;
			last_c  = qcpu_rd_q;
			last_d  = prv_rd_q;
			cnt_c   = qcpu_rd_q;
			if (first_q[qcpu_rd_q] == addr_q) begin
				first_we = 1'b1;
			end else begin
				nxt_we = 1'b1;
				nxt_wa = prv_rd_q;
				nxt_wd = nxt_rd_q;
			end
			if (last_q[qcpu_rd_q] == addr_q) begin
				last_we = 1'b1;
			end else begin
				prv_we = 1'b1;
				prv_wa = nxt_rd_q;
				prv_wd = prv_rd_q;
			end
			cnt_we  = (cnt_uc != '0);
			cnt_d   = cnt_uc - QW'(1);
			stat_we = 1'b1;
			stat_wd = pcrr_pkg::ST_TAKEN;
		end else if (ex_en) begin
			stat_we = 1'b1;
			stat_wd = pcrr_pkg::ST_EXITED;
		end
	end

	always_ff @(posedge clk) begin
		if (first_we) first_q[first_c] <= first_d;
		if (last_we) last_q[last_c] <= last_d;
		if (cmd.ex_a) ret_q <= run_vld_q[cpu_q] && exit_q;
		if (res_we) begin
			status          <= r_status;
			switched        <= r_sw;
			pick_thread     <= r_chosen;
			chosen_is_idle  <= r_cidle;
			granted_budget  <= r_grant;
			retired_current <= r_ret;
			queue_length    <= r_qlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcrr_pkg::CPUS; i++) begin
				cnt_q[i]     <= '0;
				run_thr_q[i] <= '0;
			end
			run_vld_q  <= '0;
			run_idle_q <= '0;
		end else begin
			if (cnt_we) cnt_q[cnt_c] <= cnt_d;
			if (run_we) begin
				run_thr_q[cpu_q]  <= run_thr_d;
				run_vld_q[cpu_q]  <= 1'b1;
				run_idle_q[cpu_q] <= run_idle_d;
			end
		end
	end

endmodule

>>> src/per_cpu_round_robin_scheduler_top.sv
// Per-CPU round robin ready queue scheduler, top level.
// Each item gets a table read and an update before its result is presented; a schedule that
// goes on to choose makes a second read and update, of the head of its CPU's queue.
// One item at a time: a new item is accepted only once the last result has been taken, so
// an output stall holds off the next item.
// Reset clears all thread status, queue counts and running state at once; no sweep.
module per_cpu_round_robin_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        default_budget_we,
	input  logic [7:0]  default_budget_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// thread_index, thread_is_idle, no_affinity, affinity_cpu, calling_cpu,
	// current_exiting, current_waiting, current_budget
	input  logic [31:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, switched, pick_thread, chosen_is_idle, granted_budget,
	// retired_current, queue_length
	output logic [31:0] m_tdata
);

	pcrr_pkg::cmd_t cmd;
	pcrr_pkg::sts_t sts;

	logic       status, switched, chosen_is_idle, retired_current;
	logic [5:0] pick_thread;
	logic [7:0] granted_budget;
	logic [6:0] queue_length;

	pcrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcrr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.budget_we       (default_budget_we),
		.budget_wdata    (default_budget_wdata),
		.in_kind         (s_tuser),
		.in_thread       (s_tdata[5:0]),
		.in_idle         (s_tdata[6]),
		.in_noaff        (s_tdata[7]),
		.in_aff          (s_tdata[15:8]),
		.in_cpu          (s_tdata[17:16]),
		.in_exit         (s_tdata[18]),
		.in_wait         (s_tdata[19]),
		.in_budget       (s_tdata[27:20]),
		.status          (status),
		.switched        (switched),
		.pick_thread     (pick_thread),
		.chosen_is_idle  (chosen_is_idle),
		.granted_budget  (granted_budget),
		.retired_current (retired_current),
		.queue_length    (queue_length)
	);

	assign m_tdata = {7'd0, queue_length, retired_current, granted_budget,
		chosen_is_idle, pick_thread, switched, status};

endmodule
